FILE: rtl/core/block_average_to_ascii_macros.svh
// Assertion shorthands for the block_average_to_ascii checker.
// Both expect a signal named clk, and BAA_ASSERT also rst_n, in the scope that uses them.
`ifndef BLOCK_AVERAGE_TO_ASCII_MACROS_SVH
`define BLOCK_AVERAGE_TO_ASCII_MACROS_SVH

// Checked only while out of reset.
`define BAA_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every edge, reset included.
`define BAA_ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: rtl/core/baa_pkg.sv
`timescale 1ns / 1ps

package baa_pkg;

  // field and state widths
  localparam int PIX_W  = 8;
  localparam int SIDE_W = 7;
  localparam int CNT_W  = 9;
  localparam int IW_W   = 15;
  localparam int PC_W   = 14;
  localparam int CHAR_W = 7;
  localparam int SUM_W  = 20;
  localparam int N_W    = 14;
  localparam int THR_W  = 23;
  localparam int ADDR_W = 5;
  localparam int DATA_W = 32;
  localparam int CROW_W = 8;

  localparam int DEF_MAX_CELLS_ACROSS = 256;
  localparam int DEF_MAX_BLOCK_SIDE   = 64;

  // register reset values
  localparam logic [SIDE_W-1:0] RST_BLOCK_WIDTH  = 7'd1;
  localparam logic [SIDE_W-1:0] RST_BLOCK_HEIGHT = 7'd1;
  localparam logic [CNT_W-1:0]  RST_CELLS_ACROSS = 9'd164;
  localparam logic [CNT_W-1:0]  RST_CELLS_DOWN   = 9'd48;
  localparam logic [IW_W-1:0]   RST_IMAGE_WIDTH  = 15'd164;

  localparam logic [CNT_W-1:0] CELLS_DOWN_LIM  = 9'd256;
  localparam logic [IW_W-1:0]  IMAGE_WIDTH_LIM = 15'd16384;

  // glyph thresholds: avg >= 28*k + 1 for k = 1..8
  localparam logic [3:0] GLYPH_STEPS = 4'd8;
  localparam int         GLYPH_FIRST = 29;
  localparam int         GLYPH_STEP  = 28;

  typedef enum logic [2:0] {
    REG_BLOCK_WIDTH  = 3'd0,
    REG_BLOCK_HEIGHT = 3'd1,
    REG_CELLS_ACROSS = 3'd2,
    REG_CELLS_DOWN   = 3'd3,
    REG_IMAGE_WIDTH  = 3'd4
  } baa_reg_t;

  typedef enum logic [2:0] {
    ST_EFF_GO,
    ST_EFF_WAIT,
    ST_POS_GO,
    ST_POS_WAIT,
    ST_RUN
  } baa_state_t;

  typedef struct packed {
    logic              start;
    logic [IW_W-1:0]   dividend;
    logic [SIDE_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [IW_W-1:0]   quotient;
    logic [SIDE_W-1:0] remainder;
  } div_rsp_t;

  // ".,-+=xX@#"
  function automatic logic [CHAR_W-1:0] glyph_char(input logic [3:0] idx);
    logic [CHAR_W-1:0] c;
    case (idx)
      4'd0:    c = 7'h2E;
      4'd1:    c = 7'h2C;
      4'd2:    c = 7'h2D;
      4'd3:    c = 7'h2B;
      4'd4:    c = 7'h3D;
      4'd5:    c = 7'h78;
      4'd6:    c = 7'h58;
      4'd7:    c = 7'h40;
      default: c = 7'h23;
    endcase
    return c;
  endfunction

endpackage

FILE: rtl/core/baa_div.sv
`timescale 1ns / 1ps

// Restoring divider, one quotient bit per cycle.
module baa_div import baa_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  div_req_t req,
  output div_rsp_t rsp
);

  localparam int STEPS = IW_W;
  localparam int CW    = $clog2(STEPS + 1);

  logic              busy_r;
  logic              done_r;
  logic [CW-1:0]     cnt_r;
  logic [IW_W-1:0]   quo_r;
  logic [SIDE_W-1:0] rem_r;
  logic [SIDE_W-1:0] dsr_r;

  logic [SIDE_W:0]   shifted;
  logic [SIDE_W:0]   diff;
  logic              ge;
  logic [SIDE_W-1:0] rem_nxt;

  assign shifted = {rem_r, quo_r[IW_W-1]};
  assign ge      = shifted >= {1'b0, dsr_r};
  assign diff    = shifted - {1'b0, dsr_r};
  assign rem_nxt = ge ? diff[SIDE_W-1:0] : shifted[SIDE_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(STEPS);
      end else if (busy_r) begin
        cnt_r <= cnt_r - CW'(1);
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      quo_r <= req.dividend;
      rem_r <= '0;
      dsr_r <= req.divisor;
    end else if (busy_r) begin
      quo_r <= {quo_r[IW_W-2:0], ge};
      rem_r <= rem_nxt;
    end
  end

  assign rsp.done      = done_r;
  assign rsp.quotient  = quo_r;
  assign rsp.remainder = rem_r;

endmodule

FILE: rtl/core/block_average_to_ascii.sv
`timescale 1ns / 1ps

// A pixel that closes a cell passes stage B, the glyph pick and the output register in turn.
// Throughput: one pixel per cycle; a cell-closing pixel stalls the input through the 8-step
//   serial threshold compare until its character is loaded. Other pixels flow back to back.
// After reset and after every register write a divider pass rebuilds the grid position
//   before pixels are taken. Reset is synchronous, active low: registers go to defaults,
//   positions clear; the sum memory is not cleared.
module block_average_to_ascii import baa_pkg::*; #(
  parameter int MAX_CELLS_ACROSS = DEF_MAX_CELLS_ACROSS,
  parameter int MAX_BLOCK_SIDE   = DEF_MAX_BLOCK_SIDE
) (
  input  logic              clk,
  input  logic              rst_n,
  // pixel input
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [PIX_W-1:0]  in_pixel,
  input  logic              in_frame_start,
  // character output
  output logic              out_valid,
  input  logic              out_stall,
  output logic [CHAR_W-1:0] out_char_code,
  output logic              out_end_of_line,
  // register port
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  localparam int AW = (MAX_CELLS_ACROSS > 1) ? $clog2(MAX_CELLS_ACROSS) : 1;
  localparam int RW = (MAX_BLOCK_SIDE > 1) ? $clog2(MAX_BLOCK_SIDE) : 1;
  localparam logic [12:0] CA_LIM   = 13'(MAX_CELLS_ACROSS);
  localparam logic [8:0]  SIDE_LIM = 9'(MAX_BLOCK_SIDE);

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [SIDE_W-1:0] bw_r, bh_r;
  logic [CNT_W-1:0]  ca_r, cd_r;
  logic [IW_W-1:0]   iw_r;
  logic              cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bw_r <= RST_BLOCK_WIDTH;
      bh_r <= RST_BLOCK_HEIGHT;
      ca_r <= RST_CELLS_ACROSS;
      cd_r <= RST_CELLS_DOWN;
      iw_r <= RST_IMAGE_WIDTH;
    end else if (cfg_wr) begin
      case (baa_reg_t'(paddr[ADDR_W-1:2]))
        REG_BLOCK_WIDTH:  bw_r <= pwdata[SIDE_W-1:0];
        REG_BLOCK_HEIGHT: bh_r <= pwdata[SIDE_W-1:0];
        REG_CELLS_ACROSS: ca_r <= pwdata[CNT_W-1:0];
        REG_CELLS_DOWN:   cd_r <= pwdata[CNT_W-1:0];
        REG_IMAGE_WIDTH:  iw_r <= pwdata[IW_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (baa_reg_t'(paddr[ADDR_W-1:2]))
      REG_BLOCK_WIDTH:  prdata = DATA_W'(bw_r);
      REG_BLOCK_HEIGHT: prdata = DATA_W'(bh_r);
      REG_CELLS_ACROSS: prdata = DATA_W'(ca_r);
      REG_CELLS_DOWN:   prdata = DATA_W'(cd_r);
      REG_IMAGE_WIDTH:  prdata = DATA_W'(iw_r);
      default:          prdata = '0;
    endcase
  end

  // Effective values: zero acts as one, oversize values saturate.
  logic [SIDE_W-1:0] bw_c, bh_c;
  logic [CNT_W-1:0]  ca_c, cd_c;
  logic [IW_W-1:0]   iw_c;

  assign bw_c = (bw_r == '0) ? SIDE_W'(1) :
                (9'(bw_r) > SIDE_LIM) ? SIDE_LIM[SIDE_W-1:0] : bw_r;
  assign bh_c = (bh_r == '0) ? SIDE_W'(1) :
                (9'(bh_r) > SIDE_LIM) ? SIDE_LIM[SIDE_W-1:0] : bh_r;
  assign ca_c = (ca_r == '0) ? CNT_W'(1) :
                (13'(ca_r) > CA_LIM) ? CA_LIM[CNT_W-1:0] : ca_r;
  assign cd_c = (cd_r == '0) ? CNT_W'(1) :
                (cd_r > CELLS_DOWN_LIM) ? CELLS_DOWN_LIM : cd_r;
  assign iw_c = (iw_r == '0) ? IW_W'(1) :
                (iw_r > IMAGE_WIDTH_LIM) ? IMAGE_WIDTH_LIM : iw_r;

  // ---------------------------------------------------------------------------
  // Setup sequencer: the divider derives cells per row (image_width / block_width,
  // capped at cells_across) and the cell index and offset of the current column.
  // ---------------------------------------------------------------------------
  baa_state_t state_r, state_nxt;
  div_req_t   div_req;
  div_rsp_t   div_rsp;

  logic [PC_W-1:0]   pc_r, pc_nxt;
  logic [SIDE_W-1:0] off_r, off_nxt;
  logic [PC_W-1:0]   cell_r, cell_nxt;
  logic [RW-1:0]     row_r, row_nxt;
  logic [CROW_W-1:0] crow_r, crow_nxt;
  logic              done_r, done_nxt;
  logic [CNT_W-1:0]  eff_r;
  logic [N_W-1:0]    n_r;

  baa_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_EFF_GO;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt        = state_r;
    div_req.start    = 1'b0;
    div_req.dividend = iw_c;
    div_req.divisor  = bw_c;
    case (state_r)
      ST_EFF_GO: begin
        div_req.start = 1'b1;
        state_nxt     = ST_EFF_WAIT;
      end
      ST_EFF_WAIT: begin
        if (div_rsp.done) state_nxt = ST_POS_GO;
      end
      ST_POS_GO: begin
        div_req.start    = 1'b1;
        div_req.dividend = IW_W'(pc_r);
        state_nxt        = ST_POS_WAIT;
      end
      ST_POS_WAIT: begin
        if (div_rsp.done) state_nxt = ST_RUN;
      end
      ST_RUN: ;
      default: state_nxt = ST_EFF_GO;
    endcase
    // any register write restarts the setup pass
    if (cfg_wr) state_nxt = ST_EFF_GO;
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_EFF_GO) n_r <= N_W'(bw_c * bh_c);
    if (state_r == ST_EFF_WAIT && div_rsp.done) begin
      eff_r <= (div_rsp.quotient > IW_W'(ca_c)) ? ca_c : div_rsp.quotient[CNT_W-1:0];
    end
  end

  // ---------------------------------------------------------------------------
  // Stage A: take a pixel, issue the sum read, step the raster position
  // ---------------------------------------------------------------------------
  logic              in_acc;
  logic              b_valid_r, b_finish_r;
  logic              g_busy_r;

  logic [PC_W-1:0]   pc_cur, cell_cur;
  logic [SIDE_W-1:0] off_cur;
  logic [RW-1:0]     row_cur;
  logic [CROW_W-1:0] crow_cur;
  logic              done_cur;
  logic              in_grid, first_px, last_px, last_cell;
  logic [AW-1:0]     rd_addr;

  assign in_stall = (state_r != ST_RUN) || g_busy_r || (b_valid_r && b_finish_r);
  assign in_acc   = in_valid && !in_stall;

  // frame start clears the position before this pixel is placed
  assign pc_cur   = in_frame_start ? '0 : pc_r;
  assign off_cur  = in_frame_start ? '0 : off_r;
  assign cell_cur = in_frame_start ? '0 : cell_r;
  assign row_cur  = in_frame_start ? '0 : row_r;
  assign crow_cur = in_frame_start ? '0 : crow_r;
  assign done_cur = in_frame_start ? 1'b0 : done_r;

  assign in_grid   = PC_W'(eff_r) > cell_cur;
  assign first_px  = (row_cur == '0) && (off_cur == '0);
  assign last_px   = (9'(row_cur) == 9'(bh_c) - 9'd1) && (off_cur == bw_c - SIDE_W'(1));
  assign last_cell = cell_cur == PC_W'(eff_r) - PC_W'(1);
  assign rd_addr   = cell_cur[AW-1:0];

  always_comb begin
    pc_nxt   = pc_r;
    off_nxt  = off_r;
    cell_nxt = cell_r;
    row_nxt  = row_r;
    crow_nxt = crow_r;
    done_nxt = done_r;
    if (state_r == ST_POS_WAIT && div_rsp.done) begin
      cell_nxt = div_rsp.quotient[PC_W-1:0];
      off_nxt  = div_rsp.remainder;
    end
    if (in_acc) begin
      pc_nxt   = pc_cur;
      off_nxt  = off_cur;
      cell_nxt = cell_cur;
      row_nxt  = row_cur;
      crow_nxt = crow_cur;
      done_nxt = done_cur;
      if (!done_cur) begin
        if (IW_W'(pc_cur) + IW_W'(1) >= iw_c) begin
          // end of image row
          pc_nxt   = '0;
          off_nxt  = '0;
          cell_nxt = '0;
          if (9'(row_cur) + 9'd1 >= 9'(bh_c)) begin
            row_nxt = '0;
            if (9'(crow_cur) + 9'd1 >= cd_c) begin
              crow_nxt = '0;
              done_nxt = 1'b1;
            end else begin
              crow_nxt = crow_cur + CROW_W'(1);
            end
          end else begin
            row_nxt = row_cur + RW'(1);
          end
        end else begin
          pc_nxt = pc_cur + PC_W'(1);
          if (8'(off_cur) + 8'd1 == 8'(bw_c)) begin
            off_nxt  = '0;
            cell_nxt = cell_cur + PC_W'(1);
          end else begin
            off_nxt = off_cur + SIDE_W'(1);
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r   <= '0;
      off_r  <= '0;
      cell_r <= '0;
      row_r  <= '0;
      crow_r <= '0;
      done_r <= 1'b0;
    end else begin
      pc_r   <= pc_nxt;
      off_r  <= off_nxt;
      cell_r <= cell_nxt;
      row_r  <= row_nxt;
      crow_r <= crow_nxt;
      done_r <= done_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage B: read-modify-write of the column sum. A read of the entry being
  // written in the same edge takes the bypass copy instead of the stale word.
  // ---------------------------------------------------------------------------
  logic [SUM_W-1:0] sums_mem [MAX_CELLS_ACROSS];
  logic [SUM_W-1:0] rd_data_r;
  logic [SUM_W-1:0] wsum_r;
  logic [PIX_W-1:0] b_pix_r;
  logic             b_first_r, b_eol_r, b_fwd_r;
  logic [AW-1:0]    b_addr_r;
  logic [SUM_W-1:0] sum_base, sum_new;

  assign sum_base = b_fwd_r ? wsum_r : rd_data_r;
  assign sum_new  = b_first_r ? SUM_W'(b_pix_r) : sum_base + SUM_W'(b_pix_r);

  always_ff @(posedge clk) begin
    rd_data_r <= sums_mem[rd_addr];
    if (b_valid_r) sums_mem[b_addr_r] <= sum_new;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_valid_r <= 1'b0;
    end else begin
      b_valid_r <= in_acc && !done_cur && in_grid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      b_pix_r    <= in_pixel;
      b_first_r  <= first_px;
      b_finish_r <= last_px;
      b_eol_r    <= last_cell;
      b_addr_r   <= rd_addr;
      b_fwd_r    <= b_valid_r && (b_addr_r == rd_addr);
    end
    if (b_valid_r) wsum_r <= sum_new;
  end

  // ---------------------------------------------------------------------------
  // Glyph pick: the index is the count of thresholds (28k+1)*N the sum reaches,
  // which equals the capped (avg-1)/28 without a divider. One compare a cycle.
  // ---------------------------------------------------------------------------
  logic [3:0]       g_cnt_r, g_idx_r;
  logic [SUM_W-1:0] g_sum_r;
  logic [THR_W-1:0] g_thr_r, g_step_r;
  logic             g_eol_r;
  logic             g_ready, out_load, b_close;
  logic             out_valid_r;

  assign b_close  = b_valid_r && b_finish_r;
  assign g_ready  = g_busy_r && (g_cnt_r == GLYPH_STEPS);
  assign out_load = g_ready && (!out_valid_r || !out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      g_busy_r <= 1'b0;
    end else if (b_close) begin
      g_busy_r <= 1'b1;
    end else if (out_load) begin
      g_busy_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (b_close) begin
      g_sum_r  <= sum_new;
      g_thr_r  <= THR_W'(n_r * GLYPH_FIRST);
      g_step_r <= THR_W'(n_r * GLYPH_STEP);
      g_cnt_r  <= '0;
      g_idx_r  <= '0;
      g_eol_r  <= b_eol_r;
    end else if (g_busy_r && !g_ready) begin
      if (THR_W'(g_sum_r) >= g_thr_r) g_idx_r <= g_idx_r + 4'd1;
      g_thr_r <= g_thr_r + g_step_r;
      g_cnt_r <= g_cnt_r + 4'd1;
    end
  end

  // ---------------------------------------------------------------------------
  // Output register
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_char_code   <= glyph_char(g_idx_r);
      out_end_of_line <= g_eol_r;
    end
  end

  assign out_valid = out_valid_r;

endmodule

FILE: rtl/core/baa_chk.sv
`timescale 1ns / 1ps
`include "block_average_to_ascii_macros.svh"

module baa_chk (
  input logic clk,
  input logic rst_n,
  input logic in_stall,
  input logic out_valid,
  input logic out_stall,
  input logic psel,
  input logic penable,
  input logic pwrite,
  input logic pready
);

  `BAA_ASSERT_RST(a_pready_high, pready, "pready dropped")
  `BAA_ASSERT_RST(a_rst_clears_out, !rst_n |=> !out_valid, "item shown right after reset")
  `BAA_ASSERT_RST(a_rst_blocks_in, !rst_n |=> in_stall, "pixels taken before setup pass")
  `BAA_ASSERT(a_cfg_write_stalls, psel && penable && pwrite |=> in_stall, "no setup pass after write")
  `BAA_ASSERT(a_out_holds, out_valid && out_stall |=> out_valid, "stalled item dropped")

endmodule

bind block_average_to_ascii baa_chk u_baa_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .psel      (psel),
  .penable   (penable),
  .pwrite    (pwrite),
  .pready    (pready)
);

FILE: verif/tb_top.sv
`timescale 1ns / 1ps

// Scoreboard for the character stream: mirrors the cell grid of the block,
// keeps the register copies and a queue of characters still to arrive.
typedef struct {
  logic [baa_pkg::CHAR_W-1:0] code;
  logic                       eol;
} char_item_t;

class char_scoreboard;
  logic [baa_pkg::SUM_W-1:0] col_sums [256];
  int unsigned col_pos, row_pos, cell_row_pos;
  bit          frame_over;
  int unsigned bw_reg, bh_reg, ca_reg, cd_reg, iw_reg;
  char_item_t  char_q [$];
  int          failures;
  string       glyph_set;

  function new();
    glyph_set = ".,-+=xX@#";
    col_pos = 0;
    row_pos = 0;
    cell_row_pos = 0;
    frame_over = 0;
    bw_reg = baa_pkg::RST_BLOCK_WIDTH;
    bh_reg = baa_pkg::RST_BLOCK_HEIGHT;
    ca_reg = baa_pkg::RST_CELLS_ACROSS;
    cd_reg = baa_pkg::RST_CELLS_DOWN;
    iw_reg = baa_pkg::RST_IMAGE_WIDTH;
    failures = 0;
  endfunction

  // zero acts as one, anything above the limit acts as the limit
  function int unsigned clamp_reg(int unsigned v, int unsigned hi);
    if (v == 0) return 1;
    if (v > hi) return hi;
    return v;
  endfunction

  function void flag(string what, int unsigned want, int unsigned got);
    failures++;
    if (failures <= 10)
      $display("%0t mismatch %s: expected %0d actual %0d", $time, what, want, got);
  endfunction

  function void write_reg(int idx, int unsigned val);
    case (idx)
      baa_pkg::REG_BLOCK_WIDTH:  bw_reg = val & 32'h7F;
      baa_pkg::REG_BLOCK_HEIGHT: bh_reg = val & 32'h7F;
      baa_pkg::REG_CELLS_ACROSS: ca_reg = val & 32'h1FF;
      baa_pkg::REG_CELLS_DOWN:   cd_reg = val & 32'h1FF;
      baa_pkg::REG_IMAGE_WIDTH:  iw_reg = val & 32'h7FFF;
      default: ;
    endcase
  endfunction

  function int unsigned reg_value(int idx);
    case (idx)
      baa_pkg::REG_BLOCK_WIDTH:  return bw_reg;
      baa_pkg::REG_BLOCK_HEIGHT: return bh_reg;
      baa_pkg::REG_CELLS_ACROSS: return ca_reg;
      baa_pkg::REG_CELLS_DOWN:   return cd_reg;
      default:                   return iw_reg;
    endcase
  endfunction

  // one accepted pixel: advance the grid position, queue a character if a cell closes
  function void note_pixel(logic [7:0] pix, logic fs);
    int unsigned bw, bh, ca, cd, iw, cells_used, cell_idx, off, avg, gi;
    char_item_t  c;
    bw = clamp_reg(bw_reg, baa_pkg::DEF_MAX_BLOCK_SIDE);
    bh = clamp_reg(bh_reg, baa_pkg::DEF_MAX_BLOCK_SIDE);
    ca = clamp_reg(ca_reg, baa_pkg::DEF_MAX_CELLS_ACROSS);
    cd = clamp_reg(cd_reg, baa_pkg::CELLS_DOWN_LIM);
    iw = clamp_reg(iw_reg, baa_pkg::IMAGE_WIDTH_LIM);
    cells_used = iw / bw;
    if (cells_used > ca) cells_used = ca;
    if (fs) begin
      col_pos = 0;
      row_pos = 0;
      cell_row_pos = 0;
      frame_over = 0;
    end
    if (frame_over) return;
    if (col_pos < cells_used * bw) begin
      cell_idx = (col_pos / bw) % 256;
      off = col_pos % bw;
      if (row_pos == 0 && off == 0)
        col_sums[cell_idx] = pix;
      else
        col_sums[cell_idx] = col_sums[cell_idx] + pix;
      if (row_pos == bh - 1 && off == bw - 1) begin
        avg = col_sums[cell_idx] / (bw * bh);
        gi = (avg == 0) ? 0 : (avg - 1) / baa_pkg::GLYPH_STEP;
        if (gi > baa_pkg::GLYPH_STEPS) gi = baa_pkg::GLYPH_STEPS;
        c.code = glyph_set[gi];
        c.eol = (cell_idx == cells_used - 1);
        char_q.push_back(c);
      end
    end
    if (col_pos + 1 >= iw) begin
      col_pos = 0;
      if (row_pos + 1 >= bh) begin
        row_pos = 0;
        if (cell_row_pos + 1 >= cd) begin
          cell_row_pos = 0;
          frame_over = 1;
        end else begin
          cell_row_pos++;
        end
      end else begin
        row_pos++;
      end
    end else begin
      col_pos++;
    end
  endfunction

  function void check_char(logic [6:0] code, logic eol);
    char_item_t c;
    if (char_q.size() == 0) begin
      failures++;
      if (failures <= 10)
        $display("%0t unexpected character %0d eol %0d", $time, code, eol);
      return;
    end
    c = char_q.pop_front();
    if (code !== c.code) flag("char_code", c.code, code);
    if (eol !== c.eol) flag("end_of_line", c.eol, eol);
  endfunction

  function int pending();
    return char_q.size();
  endfunction
endclass

module tb_top;
  import baa_pkg::*;

  // register index past the end of the map; writes there must be ignored
  localparam int REG_UNUSED_IDX = 5;
  // cycles allowed after the last character before the block counts as idle
  localparam int SETTLE_CYCLES  = 40;
  // longest frame sent in one piece; longer ones get cut short
  localparam int FRAME_CAP      = 600;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [PIX_W-1:0]  in_pixel = '0;
  logic              in_frame_start = 1'b0;
  logic              out_valid;
  logic              out_stall = 1'b1;
  logic [CHAR_W-1:0] out_char_code;
  logic              out_end_of_line;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [DATA_W-1:0] pwdata = '0;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  char_scoreboard sb;
  int send_gap_max = 9;   // sender idle draw ceiling, 0 gives back-to-back stretches
  int long_hold = 0;      // receiver stall length requested for the next item

  block_average_to_ascii dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_pixel        (in_pixel),
    .in_frame_start  (in_frame_start),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_char_code   (out_char_code),
    .out_end_of_line (out_end_of_line),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  always #5 clk = ~clk;

  // Result side: every character accepted is checked against the oldest expectation.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      sb.check_char(out_char_code, out_end_of_line);
  end

  // Receiver: random stall before each item, ceiling flips between 0 and 9 so some
  // stretches run with no stall at all. A long hold, when requested, makes the block
  // back up and stall its pixel input while the sender keeps offering.
  initial begin
    int n, rx_gap_max, taken;
    rx_gap_max = 9;
    taken = 0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      n = $urandom_range(0, rx_gap_max);
      if (long_hold > 0) begin
        n = long_hold;
        long_hold = 0;
      end
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      taken++;
      if (taken % 64 == 0)
        rx_gap_max = ($urandom_range(0, 2) == 0) ? 0 : 9;
    end
  end

  // Register write: setup cycle, then access; the write lands at the access edge.
  // The bus then goes idle before the task returns, so the next transfer starts in a later time step.
  task automatic apb_write(int idx, int unsigned val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_W'(idx << 2);
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    sb.write_reg(idx, val);
    @(posedge clk);
  endtask

  task automatic apb_read(int idx, output int unsigned val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= ADDR_W'(idx << 2);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    val = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // write a register and read it back
  task automatic set_reg(baa_reg_t r, int unsigned val);
    int unsigned rd;
    apb_write(r, val);
    apb_read(r, rd);
    if (rd !== sb.reg_value(r)) sb.flag("register readback", sb.reg_value(r), rd);
  endtask

  // One pixel: random idle gap, then hold valid until the block takes it.
  task automatic send_pixel(logic [7:0] pix, logic fs);
    int n;
    n = $urandom_range(0, send_gap_max);
    if (n > 0) begin
      in_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_pixel       <= pix;
    in_frame_start <= fs;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_pixel(pix, fs);
  endtask

  // Wait for all queued characters, then let any pixel still in flight settle.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Pixel value for the current frame style: flat random, a noisy level, or extremes.
  function automatic logic [7:0] draw_pixel(int style, int level, int spread);
    int v;
    case (style)
      0: v = $urandom_range(0, 255);
      1: v = level + $urandom_range(0, 2 * spread) - spread;
      default: v = ($urandom_range(0, 1) == 1) ? 255 : 0;
    endcase
    if (v < 0) v = 0;
    if (v > 255) v = 255;
    return v[7:0];
  endfunction

  // One configuration phase: program the grid, then mostly whole frames with random
  // content; some frames get cut short and some are followed by stray pixels sent without
  // a frame start, which land after the frame is done unless it was cut short.
  task automatic run_phase(int unsigned bw, int unsigned bh, int unsigned ca,
                           int unsigned cd, int unsigned iw, int budget, bit hold);
    int sent, frame_len, len, style, level, spread, i;
    set_reg(REG_BLOCK_WIDTH, bw);
    set_reg(REG_BLOCK_HEIGHT, bh);
    set_reg(REG_CELLS_ACROSS, ca);
    set_reg(REG_CELLS_DOWN, cd);
    set_reg(REG_IMAGE_WIDTH, iw);
    frame_len = sb.clamp_reg(iw, IMAGE_WIDTH_LIM) * sb.clamp_reg(bh, DEF_MAX_BLOCK_SIDE)
              * sb.clamp_reg(cd, CELLS_DOWN_LIM);
    if (frame_len > FRAME_CAP) frame_len = FRAME_CAP;
    send_gap_max = ($urandom_range(0, 2) == 0) ? 0 : 9;
    if (hold) begin
      send_gap_max = 0;
      long_hold = 300;
    end
    sent = 0;
    while (sent < budget) begin
      len = frame_len;
      if ($urandom_range(0, 99) < 12) len = $urandom_range(1, frame_len);
      // frames never run past the phase's pixel budget; stray pixels are not counted in it
      if (len > budget - sent) len = budget - sent;
      style = $urandom_range(0, 3);
      if (style == 3) style = 1;
      level = $urandom_range(0, 255);
      spread = $urandom_range(0, 31);
      // first pixel after a register write always opens a frame, so no cell
      // can close on a sum that was never started
      for (i = 0; i < len; i++)
        send_pixel(draw_pixel(style, level, spread),
                   (i == 0) || ($urandom_range(0, 299) == 0));
      sent += len;
      if ($urandom_range(0, 3) == 0)
        repeat ($urandom_range(1, 3)) send_pixel(draw_pixel(0, 0, 0), 1'b0);
    end
    drain();
  endtask

  initial begin
    int unsigned corner_pix [21];
    int i;
    corner_pix = '{0, 1, 28, 29, 56, 57, 84, 85, 112, 113, 140, 141,
                   168, 169, 196, 197, 224, 225, 252, 253, 255};
    sb = new();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Reset grid is 1x1 cells: each pixel is its own average, so every glyph
    // boundary and the capped top range can be hit directly.
    for (i = 0; i < 21; i++)
      send_pixel(corner_pix[i][7:0], i == 0);
    drain();

    run_phase(2, 2, 4, 3, 9, 100, 0);          // pixels right of the grid ignored
    run_phase(1, 1, 1, 1, 1, 60, 0);           // smallest grid, one-pixel frames
    run_phase(64, 1, 2, 2, 133, 120, 0);       // widest cell
    run_phase(1, 64, 3, 1, 3, 192, 0);         // tallest cell
    run_phase(0, 0, 0, 0, 0, 40, 0);           // zero values act as one
    run_phase(100, 0, 511, 2, 130, 120, 0);    // oversize values saturate
    run_phase(1, 1, 256, 1, 300, 260, 1);      // full row of cells, long output hold
    run_phase(1, 1, 2, 256, 1, 256, 0);        // most cell rows
    run_phase(1, 1, 1, 400, 1, 256, 0);        // cell rows saturate
    run_phase(64, 1, 256, 1, 32767, 80, 0);    // widest image, frames cut short
    run_phase(5, 1, 4, 2, 3, 40, 0);           // grid wider than image: no cells
    apb_write(REG_UNUSED_IDX, 32'hFFFF_FFFF);  // must not disturb the map
    run_phase(3, 2, 7, 4, 23, 184, 0);
    run_phase($urandom_range(1, 8), $urandom_range(1, 4), $urandom_range(1, 20),
              $urandom_range(1, 6), $urandom_range(1, 40), 80, 0);

    if (sb.pending() != 0) sb.flag("characters left over", 0, sb.pending());
    if (sb.failures == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

  // Hard stop well past the slowest legal run.
  initial begin
    #10_000_000;
    $display("status: fail");
    $finish;
  end
endmodule

FILE: sim.f
+incdir+rtl/core
rtl/core/baa_pkg.sv
rtl/core/baa_div.sv
rtl/core/block_average_to_ascii.sv
rtl/core/baa_chk.sv
verif/tb_top.sv
